// File: rtl/core/smsd_pkg.sv
// Shared types, sizes and the character-to-segment table for the
// multiplexed seven-segment display driver. No dependencies.
`default_nettype none

package smsd_pkg;

	localparam int MSG_BUF_SIZE = 64;
	localparam int NUM_DIGITS = 4;

	// Index width holds the buffer size plus a full display window.
	localparam int IDX_W = $clog2(MSG_BUF_SIZE + NUM_DIGITS);
	localparam int BANK_DEPTH = (MSG_BUF_SIZE + NUM_DIGITS - 1) / NUM_DIGITS;
	localparam int BANK_AW = $clog2(BANK_DEPTH);

	localparam int CMD_DEPTH = 4;
	localparam int CMD_AW = $clog2(CMD_DEPTH);
	localparam int CMD_CW = $clog2(CMD_DEPTH + 1);
	localparam int OUT_DEPTH = 4;
	localparam int OUT_AW = $clog2(OUT_DEPTH);
	localparam int OUT_CW = $clog2(OUT_DEPTH + 1);

	localparam logic [15:0] PERIOD_RESET = 16'h0200;
	localparam logic [7:0] SEG_UNKNOWN = 8'h80;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_BLANK = 8'h00;
	localparam logic [7:0] DIV10_MUL = 8'd205;
	localparam int TABLE_LEN = 127;

	typedef enum logic {
		ACT_TICK = 1'b0,
		ACT_APPEND = 1'b1
	} action_t;

	typedef struct packed {
		logic append;
		logic [7:0] ch;
		logic last;
		logic [3:0] min_tens;
		logic [3:0] min_units;
		logic [3:0] sec_tens;
		logic [3:0] sec_units;
		logic timer_led;
		logic target_led;
		logic edit_led;
	} cmd_t;

	typedef struct packed {
		logic [3:0] digit_onehot;
		logic [7:0] segments;
		logic timer_led;
		logic target_led;
		logic edit_led;
	} result_t;

	localparam logic [7:0] SEG_TABLE [TABLE_LEN] = '{
		8'h00, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
		8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
		8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
		8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
		8'h00, 8'h86, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h02,
		8'h30, 8'h06, 8'h80, 8'h80, 8'h80, 8'h40, 8'h80, 8'h12,
		8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
		8'h7F, 8'h67, 8'h41, 8'h0D, 8'h80, 8'h41, 8'h80, 8'hD3,
		8'h80,
		8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h3D,
		8'h76, 8'h30, 8'h1E, 8'h76, 8'h38, 8'h80, 8'h54, 8'h3F,
		8'h73, 8'h67, 8'h50, 8'h6D, 8'h70, 8'h1C, 8'h72, 8'h80,
		8'h80, 8'h6E, 8'h80,
		8'hB9, 8'h80, 8'h8F, 8'h80, 8'h08, 8'h80,
		8'h77, 8'h7C, 8'h58, 8'h5E, 8'h79, 8'h71, 8'h3D,
		8'h74, 8'h30, 8'h1E, 8'h76, 8'h38, 8'h80, 8'h54, 8'h5C,
		8'h73, 8'h67, 8'h50, 8'h6D, 8'h70, 8'h1C, 8'h72, 8'h80,
		8'h80, 8'h6E, 8'h80,
		8'h80, 8'h30, 8'h7C, 8'h52
	};

	function automatic logic [7:0] seg_code(input logic [7:0] ch);
		logic [7:0] code;
		if (ch < 8'(TABLE_LEN)) begin
			code = SEG_TABLE[ch[6:0]];
		end else begin
			code = SEG_UNKNOWN;
		end
		return code;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/smsd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module smsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/smsd_front.sv
// Front end: accepts input items, classifies them and splits the timer
// values into decimal digits. Depends on smsd_pkg.
`default_nettype none

module smsd_front import smsd_pkg::*; (
	input wire logic push,
	output logic full,
	input wire logic action,
	input wire logic [6:0] minutes,
	input wire logic [5:0] seconds,
	input wire logic timer_paused,
	input wire logic target_active,
	input wire logic target_override,
	input wire logic edit_mode,
	input wire logic [7:0] msg_char,
	input wire logic msg_last,
	output logic cmd_push,
	output cmd_t cmd_data,
	input wire logic cmd_full
);

	logic [14:0] min_prod;
	logic [14:0] sec_prod;
	logic [3:0] min_tens;
	logic [3:0] sec_tens;
	logic [6:0] min_diff;
	logic [6:0] sec_diff;

	// Division by ten through a reciprocal multiply, exact below 1024.
	always_comb begin
		min_prod = 15'(minutes) * 15'(DIV10_MUL);
		sec_prod = 15'(seconds) * 15'(DIV10_MUL);
		min_tens = min_prod[14:11];
		sec_tens = sec_prod[14:11];
		min_diff = minutes - ({min_tens, 3'b000} + {2'b00, min_tens, 1'b0});
		sec_diff = {1'b0, seconds} - ({sec_tens, 3'b000} + {2'b00, sec_tens, 1'b0});
	end

	always_comb begin
		cmd_data.append = (action_t'(action) == ACT_APPEND);
		cmd_data.ch = msg_char;
		cmd_data.last = msg_last;
		cmd_data.min_tens = min_tens;
		cmd_data.min_units = min_diff[3:0];
		cmd_data.sec_tens = sec_tens;
		cmd_data.sec_units = sec_diff[3:0];
		cmd_data.timer_led = ~timer_paused;
		cmd_data.target_led = target_active | target_override;
		cmd_data.edit_led = edit_mode;
	end

	assign full = cmd_full;
	assign cmd_push = push & ~cmd_full;

endmodule

`default_nettype wire

// File: rtl/core/smsd_cmd_queue.sv
// Short command queue between the front end and the back end.
// Depends on smsd_pkg.
`default_nettype none

module smsd_cmd_queue import smsd_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input cmd_t wdata,
	output logic full,
	output logic valid,
	output cmd_t rdata,
	input wire logic pop
);

	cmd_t mem_q [CMD_DEPTH];
	logic [CMD_AW-1:0] wr_ptr_q;
	logic [CMD_AW-1:0] rd_ptr_q;
	logic [CMD_CW-1:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign full = (cnt_q == CMD_CW'(CMD_DEPTH));
	assign valid = (cnt_q != '0);
	assign rdata = mem_q[rd_ptr_q];
	assign do_push = push & ~full;
	assign do_pop = pop & valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + CMD_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + CMD_AW'(1);
			end
			cnt_q <= cnt_q + CMD_CW'(do_push) - CMD_CW'(do_pop);
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/smsd_back.sv
// Back end: message buffer bookkeeping, refresh counter, window reads from
// four RAM banks, segment lookup and the result queue.
// Depends on smsd_pkg and smsd_ram.
`default_nettype none

module smsd_back import smsd_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [15:0] refresh_period,
	input wire logic cmd_valid,
	input cmd_t cmd,
	output logic cmd_ready,
	output logic empty,
	output result_t res,
	input wire logic pop
);

	// Architectural state.
	logic [IDX_W-1:0] rd_idx_q;
	logic [IDX_W-1:0] end_idx_q;
	logic [IDX_W-1:0] pend_len_q;
	logic pend_ovf_q;
	logic [1:0] cur_digit_q;
	logic [15:0] refresh_cnt_q;
	logic [7:0] disp_q [NUM_DIGITS];

	// Result queue.
	result_t out_mem_q [OUT_DEPTH];
	logic [OUT_AW-1:0] out_wr_q;
	logic [OUT_AW-1:0] out_rd_q;
	logic [OUT_CW-1:0] out_cnt_q;

	// Second stage of a tick.
	logic valid_s2;
	logic reload_s2;
	logic win_s2;
	logic [1:0] base_s2;
	logic [1:0] digit_s2;
	logic [NUM_DIGITS-1:0] keep_s2;
	cmd_t cmd_s2;

	logic room;
	logic take;
	logic do_app;
	logic do_tick;

	logic drain;
	logic [IDX_W-1:0] end_b;
	logic [IDX_W-1:0] rd_b;
	logic [IDX_W-1:0] pos;
	logic [IDX_W-1:0] pos1;
	logic [IDX_W-1:0] pos2;
	logic store;
	logic commit;

	logic [15:0] cnt_inc;
	logic reload;
	logic win;
	logic [1:0] next_digit;
	logic [NUM_DIGITS-1:0] keep;

	logic [NUM_DIGITS-1:0] bank_we;
	logic [BANK_AW-1:0] bank_waddr [NUM_DIGITS];
	logic [7:0] bank_wdata [NUM_DIGITS];
	logic [BANK_AW-1:0] bank_raddr [NUM_DIGITS];
	logic [7:0] bank_rdata [NUM_DIGITS];

	logic [7:0] new_chars [NUM_DIGITS];
	logic [7:0] win_chars [NUM_DIGITS];
	logic [7:0] timer_chars [NUM_DIGITS];
	logic [7:0] show_char;
	result_t res_s2;
	logic out_push;
	logic out_pop;

	// A tick goes ahead only when the result queue has a place for it,
	// counting the one that may still be in the second stage.
	assign room = ((out_cnt_q + OUT_CW'(valid_s2)) < OUT_CW'(OUT_DEPTH));
	assign cmd_ready = cmd.append | room;
	assign take = cmd_valid & cmd_ready;
	assign do_app = take & cmd.append;
	assign do_tick = take & ~cmd.append;

	// Append bookkeeping. Once the buffer has drained, a new message
	// restarts at the bottom of the buffer.
	always_comb begin
		drain = (pend_len_q == '0) && !pend_ovf_q && (rd_idx_q == end_idx_q);
		end_b = drain ? '0 : end_idx_q;
		rd_b = drain ? '0 : rd_idx_q;
		pos = end_b + pend_len_q;
		pos1 = pos + IDX_W'(1);
		pos2 = pos + IDX_W'(2);
		store = !pend_ovf_q && (pos < IDX_W'(MSG_BUF_SIZE));
		// The message and its two blank separators must fit.
		commit = cmd.last && store && (pos <= IDX_W'(MSG_BUF_SIZE - 3));
	end

	// Consecutive positions fall in different banks, so the character and
	// both separators are written in the same cycle.
	always_comb begin
		for (int b = 0; b < NUM_DIGITS; b++) begin
			bank_we[b] = 1'b0;
			bank_waddr[b] = pos[BANK_AW+1:2];
			bank_wdata[b] = CHAR_BLANK;
			if (do_app && store && (pos[1:0] == 2'(b))) begin
				bank_we[b] = 1'b1;
				bank_wdata[b] = cmd.ch;
			end else if (do_app && commit && (pos1[1:0] == 2'(b))) begin
				bank_we[b] = 1'b1;
				bank_waddr[b] = pos1[BANK_AW+1:2];
			end else if (do_app && commit && (pos2[1:0] == 2'(b))) begin
				bank_we[b] = 1'b1;
				bank_waddr[b] = pos2[BANK_AW+1:2];
			end
		end
	end

	// Tick: refresh counter and window read addresses.
	always_comb begin
		logic [1:0] off;
		logic [IDX_W-1:0] p;
		cnt_inc = refresh_cnt_q + 16'd1;
		reload = (cnt_inc >= refresh_period);
		win = reload && (rd_idx_q != end_idx_q);
		next_digit = cur_digit_q + 2'd1;
		for (int b = 0; b < NUM_DIGITS; b++) begin
			off = 2'(b) - rd_idx_q[1:0];
			p = rd_idx_q + IDX_W'(off);
			bank_raddr[b] = p[BANK_AW+1:2];
			keep[b] = ((rd_idx_q + IDX_W'(b)) < end_idx_q);
		end
	end

	for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_bank
		smsd_ram #(
			.WIDTH(8),
			.DEPTH(BANK_DEPTH)
		) u_ram (
			.clk(clk),
			.we(bank_we[g]),
			.waddr(bank_waddr[g]),
			.wdata(bank_wdata[g]),
			.re(do_tick),
			.raddr(bank_raddr[g]),
			.rdata(bank_rdata[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
			end_idx_q <= '0;
			pend_len_q <= '0;
			pend_ovf_q <= 1'b0;
			cur_digit_q <= '0;
			refresh_cnt_q <= PERIOD_RESET - 16'd1;
		end else if (do_app) begin
			rd_idx_q <= rd_b;
			if (cmd.last) begin
				pend_len_q <= '0;
				pend_ovf_q <= 1'b0;
				end_idx_q <= commit ? (pos + IDX_W'(3)) : end_b;
			end else begin
				end_idx_q <= end_b;
				pend_len_q <= pend_len_q + IDX_W'(store);
				pend_ovf_q <= pend_ovf_q | ~store;
			end
		end else if (do_tick) begin
			refresh_cnt_q <= reload ? 16'd0 : cnt_inc;
			if (win) begin
				rd_idx_q <= rd_idx_q + IDX_W'(1);
			end
			cur_digit_q <= next_digit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= do_tick;
		end
	end

	always_ff @(posedge clk) begin
		if (do_tick) begin
			reload_s2 <= reload;
			win_s2 <= win;
			base_s2 <= rd_idx_q[1:0];
			digit_s2 <= next_digit;
			keep_s2 <= keep;
			cmd_s2 <= cmd;
		end
	end

	// Second stage: build the reloaded characters and look up the segments.
	always_comb begin
		logic [1:0] bank;
		for (int k = 0; k < NUM_DIGITS; k++) begin
			bank = base_s2 + 2'(k);
			win_chars[k] = keep_s2[k] ? bank_rdata[bank] : CHAR_BLANK;
		end
		timer_chars[0] = CHAR_ZERO + {4'b0000, cmd_s2.min_tens};
		timer_chars[1] = CHAR_ZERO + {4'b0000, cmd_s2.min_units};
		timer_chars[2] = CHAR_ZERO + {4'b0000, cmd_s2.sec_tens};
		timer_chars[3] = CHAR_ZERO + {4'b0000, cmd_s2.sec_units};
		for (int k = 0; k < NUM_DIGITS; k++) begin
			new_chars[k] = win_s2 ? win_chars[k] : timer_chars[k];
		end
		show_char = reload_s2 ? new_chars[digit_s2] : disp_q[digit_s2];
		res_s2.digit_onehot = 4'b0001 << digit_s2;
		res_s2.segments = seg_code(show_char);
		res_s2.timer_led = cmd_s2.timer_led;
		res_s2.target_led = cmd_s2.target_led;
		res_s2.edit_led = cmd_s2.edit_led;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_DIGITS; k++) begin
				disp_q[k] <= CHAR_BLANK;
			end
		end else if (valid_s2 && reload_s2) begin
			for (int k = 0; k < NUM_DIGITS; k++) begin
				disp_q[k] <= new_chars[k];
			end
		end
	end

	assign out_push = valid_s2;
	assign empty = (out_cnt_q == '0);
	assign out_pop = pop & ~empty;
	assign res = out_mem_q[out_rd_q];

	always_ff @(posedge clk) begin
		if (out_push) begin
			out_mem_q[out_wr_q] <= res_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_wr_q <= '0;
			out_rd_q <= '0;
			out_cnt_q <= '0;
		end else begin
			if (out_push) begin
				out_wr_q <= out_wr_q + OUT_AW'(1);
			end
			if (out_pop) begin
				out_rd_q <= out_rd_q + OUT_AW'(1);
			end
			out_cnt_q <= out_cnt_q + OUT_CW'(out_push) - OUT_CW'(out_pop);
		end
	end

	a_out_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_cnt_q <= OUT_CW'(OUT_DEPTH))
		else $error("result queue count out of range");

	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (out_cnt_q < OUT_CW'(OUT_DEPTH)))
		else $error("tick reached second stage without a result slot");

	a_read_behind_end: assert property (@(posedge clk) disable iff (!arst_n)
		rd_idx_q <= end_idx_q)
		else $error("read index passed end index");

	a_buffer_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(end_idx_q + pend_len_q) <= IDX_W'(MSG_BUF_SIZE))
		else $error("pending message runs past the buffer");

	a_reload_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(do_tick && reload) |=> (refresh_cnt_q == 16'd0))
		else $error("refresh counter not cleared on reload");

endmodule

`default_nettype wire

// File: rtl/core/mux_seven_segment_display.sv
// Top level of the multiplexed seven-segment display driver: front end,
// command queue, back end and the refresh period register.
// Depends on smsd_pkg, smsd_front, smsd_cmd_queue and smsd_back.
//
//   Channel   Handshake            Payload
//   -------   ------------------   ---------------------------------------------
//   input     push / full          action, minutes, seconds, timer_paused,
//                                  target_active, target_override, edit_mode,
//                                  msg_char, msg_last
//   result    empty / pop          digit_onehot, segments, timer_led,
//                                  target_led, edit_led
//   config    cfg_valid/cfg_ready  cfg_data (refresh period)
//
// One item is accepted per clock while full is low; the back end retires one
// per clock too, but holds a tick while the result queue has no room for it.
// The back end reads the four message RAM banks as a tick leaves the command
// queue, and a second stage looks up the segments for the result queue.
// arst_n clears all control state at once; there is no clearing pass.
// A full result queue stalls ticks in the back end; the command queue then
// fills and raises full.
`default_nettype none

module mux_seven_segment_display import smsd_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire logic action,
	input wire logic [6:0] minutes,
	input wire logic [5:0] seconds,
	input wire logic timer_paused,
	input wire logic target_active,
	input wire logic target_override,
	input wire logic edit_mode,
	input wire logic [7:0] msg_char,
	input wire logic msg_last,
	output logic empty,
	input wire logic pop,
	output logic [3:0] digit_onehot,
	output logic [7:0] segments,
	output logic timer_led,
	output logic target_led,
	output logic edit_led,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [15:0] cfg_data
);

	logic [15:0] refresh_period_q;
	logic cmd_push;
	cmd_t cmd_in;
	logic cmd_full;
	logic cmd_valid;
	cmd_t cmd_head;
	logic cmd_ready;
	result_t res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refresh_period_q <= PERIOD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			refresh_period_q <= cfg_data;
		end
	end

	smsd_front u_front (
		.push(push),
		.full(full),
		.action(action),
		.minutes(minutes),
		.seconds(seconds),
		.timer_paused(timer_paused),
		.target_active(target_active),
		.target_override(target_override),
		.edit_mode(edit_mode),
		.msg_char(msg_char),
		.msg_last(msg_last),
		.cmd_push(cmd_push),
		.cmd_data(cmd_in),
		.cmd_full(cmd_full)
	);

	smsd_cmd_queue u_cmd_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(cmd_push),
		.wdata(cmd_in),
		.full(cmd_full),
		.valid(cmd_valid),
		.rdata(cmd_head),
		.pop(cmd_ready)
	);

	smsd_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.refresh_period(refresh_period_q),
		.cmd_valid(cmd_valid),
		.cmd(cmd_head),
		.cmd_ready(cmd_ready),
		.empty(empty),
		.res(res),
		.pop(pop)
	);

	assign digit_onehot = res.digit_onehot;
	assign segments = res.segments;
	assign timer_led = res.timer_led;
	assign target_led = res.target_led;
	assign edit_led = res.edit_led;

endmodule

`default_nettype wire

// File: test/tb_mux_seven_segment_display.sv
// Self-checking testbench for the multiplexed seven-segment display driver.
// A clocked driver and monitor run against an in-bench prediction of every
// displayed digit. Depends on smsd_pkg and mux_seven_segment_display.
module tb_mux_seven_segment_display import smsd_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 210;

	typedef struct {
		action_t action;
		logic [6:0] minutes;
		logic [5:0] seconds;
		logic timer_paused;
		logic target_active;
		logic target_override;
		logic edit_mode;
		logic [7:0] msg_char;
		logic msg_last;
	} panel_item_t;

	typedef enum logic [1:0] {
		POP_ALWAYS,
		POP_HALF,
		POP_QUARTER,
		POP_MOSTLY
	} pop_pattern_t;

	localparam logic [7:0] GLYPHS [TABLE_LEN] = '{
		8'h00, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
		8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
		8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
		8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
		8'h00, 8'h86, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h02,
		8'h30, 8'h06, 8'h80, 8'h80, 8'h80, 8'h40, 8'h80, 8'h12,
		8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
		8'h7F, 8'h67, 8'h41, 8'h0D, 8'h80, 8'h41, 8'h80, 8'hD3,
		8'h80,
		8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h3D,
		8'h76, 8'h30, 8'h1E, 8'h76, 8'h38, 8'h80, 8'h54, 8'h3F,
		8'h73, 8'h67, 8'h50, 8'h6D, 8'h70, 8'h1C, 8'h72, 8'h80,
		8'h80, 8'h6E, 8'h80,
		8'hB9, 8'h80, 8'h8F, 8'h80, 8'h08, 8'h80,
		8'h77, 8'h7C, 8'h58, 8'h5E, 8'h79, 8'h71, 8'h3D,
		8'h74, 8'h30, 8'h1E, 8'h76, 8'h38, 8'h80, 8'h54, 8'h5C,
		8'h73, 8'h67, 8'h50, 8'h6D, 8'h70, 8'h1C, 8'h72, 8'h80,
		8'h80, 8'h6E, 8'h80,
		8'h80, 8'h30, 8'h7C, 8'h52
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic action = 1'b0;
	logic [6:0] minutes = '0;
	logic [5:0] seconds = '0;
	logic timer_paused = 1'b0;
	logic target_active = 1'b0;
	logic target_override = 1'b0;
	logic edit_mode = 1'b0;
	logic [7:0] msg_char = 8'h01;
	logic msg_last = 1'b0;
	logic empty;
	logic pop = 1'b0;
	logic [3:0] digit_onehot;
	logic [7:0] segments;
	logic timer_led;
	logic target_led;
	logic edit_led;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [15:0] cfg_data = '0;

	// Predicted display state.
	logic [7:0] text_buf [MSG_BUF_SIZE];
	int unsigned win_start;
	int unsigned text_end;
	int unsigned draft_len;
	bit draft_over;
	logic [7:0] shown_chars [NUM_DIGITS];
	logic [1:0] lit_digit;
	logic [15:0] refresh_ticks;
	logic [15:0] refresh_period_q;

	panel_item_t pending_items [$];
	result_t expected_frames [$];
	panel_item_t cur_item;
	result_t want_frame;

	int cycle_count = 0;
	int mismatches = 0;
	int results_seen = 0;
	int burst_left = 0;
	int gap_left = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int pattern_left = 0;
	pop_pattern_t pop_pattern = POP_ALWAYS;
	logic want_pop;

	mux_seven_segment_display dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.action(action),
		.minutes(minutes),
		.seconds(seconds),
		.timer_paused(timer_paused),
		.target_active(target_active),
		.target_override(target_override),
		.edit_mode(edit_mode),
		.msg_char(msg_char),
		.msg_last(msg_last),
		.empty(empty),
		.pop(pop),
		.digit_onehot(digit_onehot),
		.segments(segments),
		.timer_led(timer_led),
		.target_led(target_led),
		.edit_led(edit_led),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #5ns clk = ~clk;

	function automatic void predict_item(input panel_item_t it);
		result_t frame;
		int unsigned slot;
		int unsigned k;
		if (it.action == ACT_APPEND) begin
			// The first character of a new message rewinds a drained buffer.
			if (draft_len == 0 && !draft_over && win_start == text_end) begin
				win_start = 0;
				text_end = 0;
			end
			slot = text_end + draft_len;
			if (!draft_over && slot < MSG_BUF_SIZE) begin
				text_buf[slot] = it.msg_char;
				draft_len++;
			end else begin
				draft_over = 1'b1;
			end
			if (it.msg_last) begin
				// A message that cannot hold its two blank separators is dropped.
				if (!draft_over && text_end + draft_len + 2 <= MSG_BUF_SIZE) begin
					text_buf[text_end + draft_len] = CHAR_BLANK;
					text_buf[text_end + draft_len + 1] = CHAR_BLANK;
					text_end += draft_len + 2;
				end
				draft_len = 0;
				draft_over = 1'b0;
			end
		end else begin
			refresh_ticks = refresh_ticks + 16'd1;
			if (refresh_ticks >= refresh_period_q) begin
				if (win_start != text_end) begin
					for (k = 0; k < NUM_DIGITS; k++) begin
						slot = win_start + k;
						if (slot < text_end && slot < MSG_BUF_SIZE) begin
							shown_chars[k] = text_buf[slot];
						end else begin
							shown_chars[k] = CHAR_BLANK;
						end
					end
					win_start++;
				end else begin
					shown_chars[0] = CHAR_ZERO + 8'(it.minutes / 10);
					shown_chars[1] = CHAR_ZERO + 8'(it.minutes % 10);
					shown_chars[2] = CHAR_ZERO + 8'(it.seconds / 10);
					shown_chars[3] = CHAR_ZERO + 8'(it.seconds % 10);
				end
				refresh_ticks = '0;
			end
			lit_digit = lit_digit + 2'd1;
			frame.digit_onehot = 4'b0001 << lit_digit;
			if (shown_chars[lit_digit] < TABLE_LEN) begin
				frame.segments = GLYPHS[shown_chars[lit_digit][6:0]];
			end else begin
				frame.segments = SEG_UNKNOWN;
			end
			frame.timer_led = !it.timer_paused;
			frame.target_led = it.target_active | it.target_override;
			frame.edit_led = it.edit_mode;
			expected_frames.push_back(frame);
		end
	endfunction

	function automatic panel_item_t random_item(input action_t act);
		panel_item_t it;
		it.action = act;
		// Now and then the timer goes past its usual range to reach tens above nine.
		if ($urandom_range(0, 15) == 0) begin
			it.minutes = 7'($urandom_range(0, 127));
			it.seconds = 6'($urandom_range(0, 63));
		end else begin
			it.minutes = 7'($urandom_range(0, 99));
			it.seconds = 6'($urandom_range(0, 59));
		end
		it.timer_paused = 1'($urandom_range(0, 1));
		it.target_active = 1'($urandom_range(0, 1));
		it.target_override = 1'($urandom_range(0, 1));
		it.edit_mode = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 3) == 0) begin
			it.msg_char = 8'($urandom_range(1, 255));
		end else begin
			it.msg_char = 8'($urandom_range(32, 126));
		end
		it.msg_last = 1'($urandom_range(0, 1));
		return it;
	endfunction

	task automatic queue_random_phase(input int n_items);
		panel_item_t it;
		int added;
		int len;
		int k;
		added = 0;
		while (added < n_items) begin
			if ($urandom_range(0, 9) < 6) begin
				if ($urandom_range(0, 7) == 0) begin
					len = $urandom_range(50, 70);
				end else begin
					len = $urandom_range(1, 12);
				end
				for (k = 0; k < len; k++) begin
					it = random_item(ACT_APPEND);
					// Some messages are left open and run into the next one.
					it.msg_last = (k == len - 1) && ($urandom_range(0, 9) != 0);
					pending_items.push_back(it);
					added++;
					if ($urandom_range(0, 7) == 0) begin
						pending_items.push_back(random_item(ACT_TICK));
						added++;
					end
				end
			end
			repeat ($urandom_range(1, 24)) begin
				pending_items.push_back(random_item(ACT_TICK));
				added++;
			end
		end
	endtask

	// Waits until every item has been sent and every frame has come back, then
	// lets the pipeline settle so that trailing appends are done as well. The
	// check runs on the falling edge, after the driver has settled its ports.
	task automatic wait_idle();
		do begin
			@(negedge clk);
		end while (pending_items.size() != 0 || push || expected_frames.size() != 0);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_period(input logic [15:0] value);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_valid <= 1'b0;
		refresh_period_q = value;
	endtask

	initial begin : stimulus
		panel_item_t it;
		logic [7:0] greeting [5];
		logic [15:0] phase_periods [6];
		int k;
		for (k = 0; k < MSG_BUF_SIZE; k++) begin
			text_buf[k] = '0;
		end
		for (k = 0; k < NUM_DIGITS; k++) begin
			shown_chars[k] = '0;
		end
		win_start = 0;
		text_end = 0;
		draft_len = 0;
		draft_over = 1'b0;
		lit_digit = '0;
		refresh_period_q = PERIOD_RESET;
		refresh_ticks = PERIOD_RESET - 16'd1;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// With the reset period only the first tick reloads the display.
		repeat (2) pending_items.push_back(random_item(ACT_TICK));
		wait_idle();

		write_period(16'd1);
		it = random_item(ACT_TICK);
		it.minutes = 7'd0;
		it.seconds = 6'd0;
		{it.timer_paused, it.target_active, it.target_override, it.edit_mode} = 4'b0000;
		pending_items.push_back(it);
		it.minutes = 7'd99;
		it.seconds = 6'd59;
		{it.timer_paused, it.target_active, it.target_override, it.edit_mode} = 4'b1100;
		pending_items.push_back(it);
		it.minutes = 7'd127;
		it.seconds = 6'd63;
		{it.timer_paused, it.target_active, it.target_override, it.edit_mode} = 4'b0011;
		pending_items.push_back(it);
		it.minutes = 7'd100;
		it.seconds = 6'd60;
		{it.timer_paused, it.target_active, it.target_override, it.edit_mode} = 4'b1111;
		pending_items.push_back(it);
		greeting[0] = 8'h48;
		greeting[1] = 8'h69;
		greeting[2] = 8'h7F;
		greeting[3] = 8'hFF;
		greeting[4] = 8'h01;
		for (k = 0; k < 5; k++) begin
			it = random_item(ACT_APPEND);
			it.msg_char = greeting[k];
			it.msg_last = (k == 4);
			pending_items.push_back(it);
		end
		// The window runs past the message end into blanks, then back to the timer.
		repeat (8) pending_items.push_back(random_item(ACT_TICK));
		it = random_item(ACT_APPEND);
		it.msg_char = 8'h7E;
		it.msg_last = 1'b1;
		pending_items.push_back(it);
		repeat (3) pending_items.push_back(random_item(ACT_TICK));
		wait_idle();

		phase_periods[0] = 16'd2;
		phase_periods[1] = 16'hFFFF;
		phase_periods[2] = 16'd3;
		phase_periods[3] = 16'd1;
		phase_periods[4] = 16'($urandom_range(4, 20));
		phase_periods[5] = PERIOD_RESET;
		for (k = 0; k < 6; k++) begin
			write_period(phase_periods[k]);
			queue_random_phase(PHASE_ITEMS);
			wait_idle();
		end

		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_frames.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Sender: bursts of back-to-back items separated by random gaps.
	always @(posedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full) begin
				predict_item(cur_item);
			end
			if (push && full) begin
				// The item stays on the ports until its transfer.
			end else if (gap_left != 0) begin
				push <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_items.size() != 0) begin
				cur_item = pending_items.pop_front();
				action <= cur_item.action;
				minutes <= cur_item.minutes;
				seconds <= cur_item.seconds;
				timer_paused <= cur_item.timer_paused;
				target_active <= cur_item.target_active;
				target_override <= cur_item.target_override;
				edit_mode <= cur_item.edit_mode;
				msg_char <= cur_item.msg_char;
				msg_last <= cur_item.msg_last;
				push <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 48);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				push <= 1'b0;
			end
		end
	end

	// Receiver: checks each result transfer and stalls on a changing pattern.
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				results_seen <= results_seen + 1;
				if (expected_frames.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("result %0d arrived with nothing expected: digit=%h seg=%h",
							results_seen, digit_onehot, segments);
					end
				end else begin
					want_frame = expected_frames.pop_front();
					if (digit_onehot !== want_frame.digit_onehot
							|| segments !== want_frame.segments
							|| timer_led !== want_frame.timer_led
							|| target_led !== want_frame.target_led
							|| edit_led !== want_frame.edit_led) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("result %0d: expected %h %h %b%b%b, got %h %h %b%b%b",
								results_seen, want_frame.digit_onehot, want_frame.segments,
								want_frame.timer_led, want_frame.target_led, want_frame.edit_led,
								digit_onehot, segments, timer_led, target_led, edit_led);
						end
					end
				end
			end
			if (pattern_left == 0) begin
				pop_pattern <= pop_pattern_t'($urandom_range(0, 3));
				pattern_left <= $urandom_range(20, 150);
			end else begin
				pattern_left <= pattern_left - 1;
			end
			case (pop_pattern)
				POP_ALWAYS: want_pop = 1'b1;
				POP_HALF: want_pop = 1'($urandom_range(0, 1));
				POP_QUARTER: want_pop = (cycle_count[1:0] == 2'd0);
				default: want_pop = ($urandom_range(0, 9) != 0);
			endcase
			pop <= want_pop && (hold_left == 0);
		end
	end

	// One long receiver hold-off while plenty of items remain, so that both
	// queues fill and the input stalls.
	always @(posedge clk) begin
		if (!hold_done && results_seen >= 300 && pending_items.size() > 100) begin
			hold_left <= 400;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

endmodule
